FILE: rtl/tdr_pkg.sv
// Shared types, constants and controller/datapath interface for the depth rasterizer.
package tdr_pkg;

    // Default side of the square depth store.
    localparam int MAP_SIDE_DEF = 256;

    // Field widths.
    localparam int OP_W    = 2;
    localparam int COORD_W = 16;
    localparam int DEPTH_W = 24;
    localparam int RC_W    = 8;
    localparam int COUNT_W = 17;
    localparam int LIMIT_W = 16;

    // Internal arithmetic widths.
    localparam int DIFF_W  = 18;   // coordinate differences
    localparam int EDGE_W  = 36;   // edge function and area values
    localparam int MA_W    = 37;   // multiplier operand A
    localparam int MB_W    = 25;   // multiplier operand B
    localparam int PROD_W  = 62;   // product and depth numerator
    localparam int BOX_W   = 14;   // signed bounding box coordinates
    localparam int EXT_W   = 13;   // read coordinates compared against the store side
    localparam int STEP_W  = 5;    // divider step counter
    localparam int DIV_STEPS = DEPTH_W;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Operation codes carried in the input tuser.
    typedef enum logic [OP_W-1:0] {
        OP_DRAW  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Multiplier operand selection.
    typedef enum logic [1:0] {
        MUL_T1    = 2'd0,
        MUL_T2    = 2'd1,
        MUL_DEPTH = 2'd2
    } t_mul_sel;

    // Accumulator operation.
    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } t_acc_op;

    // Kind of result loaded into the output register.
    typedef enum logic [1:0] {
        RES_ZERO = 2'd0,
        RES_READ = 2'd1,
        RES_DRAW = 2'd2,
        RES_SKIP = 2'd3
    } t_res_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load_item;
        t_mul_sel  mul_sel;
        logic [1:0] edge_sel;
        logic [1:0] depth_sel;
        t_acc_op   acc_op;
        logic      edge_wr;
        logic      setup;
        logic      pix_init;
        logic      pix_next;
        logic      div_init;
        logic      div_step;
        logic      depth_upd;
        logic      addr_read;
        logic      sweep_init;
        logic      sweep_wr;
        logic      res_load;
        t_res_kind res_kind;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic degenerate;
        logic box_empty;
        logic covered;
        logic pix_last;
        logic sweep_last;
    } t_dp_status;

endpackage

FILE: rtl/tdr_datapath.sv
// Datapath: vertex registers, shared multiplier, edge values, divider and depth store.
module tdr_datapath
    import tdr_pkg::*;
#(
    parameter int MAP_SIDE = MAP_SIDE_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_status                o_status,
    input  logic signed [COORD_W-1:0] i_v0x,
    input  logic signed [COORD_W-1:0] i_v0y,
    input  logic        [DEPTH_W-1:0] i_v0d,
    input  logic signed [COORD_W-1:0] i_v1x,
    input  logic signed [COORD_W-1:0] i_v1y,
    input  logic        [DEPTH_W-1:0] i_v1d,
    input  logic signed [COORD_W-1:0] i_v2x,
    input  logic signed [COORD_W-1:0] i_v2y,
    input  logic        [DEPTH_W-1:0] i_v2d,
    input  logic        [RC_W-1:0]    i_col,
    input  logic        [RC_W-1:0]    i_row,
    input  logic                      i_cfg_we,
    input  logic        [LIMIT_W-1:0] i_cfg_data,
    output logic        [DEPTH_W-1:0] o_read_depth,
    output logic        [COUNT_W-1:0] o_pixels,
    output logic                      o_skipped
);

    localparam int AW        = $clog2(MAP_SIDE);
    localparam int MEM_AW    = 2 * AW;
    localparam int MEM_DEPTH = 1 << MEM_AW;
    localparam logic signed [BOX_W-1:0] SIDE_LAST = BOX_W'(MAP_SIDE - 1);
    localparam logic        [EXT_W-1:0] SIDE_EXT  = EXT_W'(MAP_SIDE);

    // Item and configuration registers.
    logic        [LIMIT_W-1:0] r_limit;
    logic signed [COORD_W-1:0] r_x [3];
    logic signed [COORD_W-1:0] r_y [3];
    logic        [DEPTH_W-1:0] r_d [3];
    logic        [RC_W-1:0]    r_col;
    logic        [RC_W-1:0]    r_row;
    logic                      r_oob;

    // Arithmetic registers.
    logic signed [EDGE_W-1:0]  r_edge [4];
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  r_acc;
    logic        [EDGE_W-1:0]  r_rem;
    logic        [DEPTH_W-1:0] r_nlo;
    logic        [DEPTH_W-1:0] r_quo;

    // Box walk registers.
    logic [AW-1:0] r_minx, r_maxx, r_miny, r_maxy, r_px, r_py;
    logic          r_box_empty;
    logic [COUNT_W-1:0] r_count;

    // Depth store and sweep address.
    logic [DEPTH_W-1:0] r_mem [MEM_DEPTH];
    logic [DEPTH_W-1:0] r_rdata;
    logic [MEM_AW-1:0]  r_sweep;

    // Result register.
    logic [DEPTH_W-1:0] r_res_depth;
    logic [COUNT_W-1:0] r_res_count;
    logic               r_res_skip;

    // Combinational signals.
    logic signed [DIFF_W-1:0] ax, ay, bx, by, qx, qy, pcx, pcy;
    logic signed [DIFF_W-1:0] dbx, dqy, dby, dqx;
    logic signed [MA_W-1:0]   ma;
    logic signed [MB_W-1:0]   mb;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [EDGE_W-1:0] wsel;
    logic        [DEPTH_W-1:0] dsel;
    logic signed [EDGE_W-1:0] area, area_mag;
    logic signed [COORD_W-1:0] minx16, maxx16, miny16, maxy16;
    logic signed [COORD_W-1:0] fx16, fy16;
    logic signed [COORD_W:0]   cx17, cy17;
    logic signed [BOX_W-1:0]  lox, loy, hix, hiy, fx, fy, cxb, cyb;
    logic [EDGE_W:0]          div_t;
    logic [EDGE_W:0]          div_a;
    logic [MEM_AW-1:0]        pix_addr, rd_addr;
    logic [EXT_W-1:0]         col_ext, row_ext;
    logic                     upd_we;

    // Edge operand selection: the edge runs from a to b, evaluated at point q.
    assign pcx = $signed(DIFF_W'({r_px, 4'b1000}));
    assign pcy = $signed(DIFF_W'({r_py, 4'b1000}));

    always_comb begin
        ax = DIFF_W'(r_x[0]);
        ay = DIFF_W'(r_y[0]);
        bx = DIFF_W'(r_x[1]);
        by = DIFF_W'(r_y[1]);
        qx = pcx;
        qy = pcy;
        case (i_cmd.edge_sel)
            2'd0: begin
                qx = DIFF_W'(r_x[2]);
                qy = DIFF_W'(r_y[2]);
            end
            2'd1: begin
                ax = DIFF_W'(r_x[1]);
                ay = DIFF_W'(r_y[1]);
                bx = DIFF_W'(r_x[2]);
                by = DIFF_W'(r_y[2]);
            end
            2'd2: begin
                ax = DIFF_W'(r_x[2]);
                ay = DIFF_W'(r_y[2]);
                bx = DIFF_W'(r_x[0]);
                by = DIFF_W'(r_y[0]);
            end
            default: begin
            end
        endcase
    end

    assign dbx = bx - ax;
    assign dqy = qy - ay;
    assign dby = by - ay;
    assign dqx = qx - ax;

    // Weight and vertex depth for the depth numerator.
    always_comb begin
        case (i_cmd.depth_sel)
            2'd0:    begin wsel = r_edge[1]; dsel = r_d[0]; end
            2'd1:    begin wsel = r_edge[2]; dsel = r_d[1]; end
            default: begin wsel = r_edge[3]; dsel = r_d[2]; end
        endcase
    end

    // Shared multiplier operands.
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_T1: begin
                ma = MA_W'(dbx);
                mb = MB_W'(dqy);
            end
            MUL_T2: begin
                ma = MA_W'(dby);
                mb = MB_W'(dqx);
            end
            MUL_DEPTH: begin
                ma = MA_W'(wsel);
                mb = $signed({1'b0, dsel});
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod_c = ma * mb;

    // Area magnitude and bounding box.
    assign area     = r_edge[0];
    assign area_mag = area[EDGE_W-1] ? -area : area;

    always_comb begin
        minx16 = r_x[0];
        maxx16 = r_x[0];
        miny16 = r_y[0];
        maxy16 = r_y[0];
        for (int k = 1; k < 3; k++) begin
            if (r_x[k] < minx16) minx16 = r_x[k];
            if (r_x[k] > maxx16) maxx16 = r_x[k];
            if (r_y[k] < miny16) miny16 = r_y[k];
            if (r_y[k] > maxy16) maxy16 = r_y[k];
        end
    end

    assign fx16 = minx16 >>> 4;
    assign fy16 = miny16 >>> 4;
    assign cx17 = ((COORD_W+1)'(maxx16) + 17'sd15) >>> 4;
    assign cy17 = ((COORD_W+1)'(maxy16) + 17'sd15) >>> 4;
    assign fx   = BOX_W'(fx16);
    assign fy   = BOX_W'(fy16);
    assign cxb  = BOX_W'(cx17);
    assign cyb  = BOX_W'(cy17);
    assign lox  = (fx < 0) ? '0 : fx;
    assign loy  = (fy < 0) ? '0 : fy;
    assign hix  = (cxb > SIDE_LAST) ? SIDE_LAST : cxb;
    assign hiy  = (cyb > SIDE_LAST) ? SIDE_LAST : cyb;

    // Divider trial subtraction.
    assign div_t = {r_rem, r_nlo[DEPTH_W-1]};
    assign div_a = (EDGE_W+1)'(unsigned'(area));

    // Store addressing.
    assign pix_addr = {r_py, r_px};
    assign col_ext  = EXT_W'(r_col);
    assign row_ext  = EXT_W'(r_row);
    assign rd_addr  = i_cmd.addr_read ? {row_ext[AW-1:0], col_ext[AW-1:0]} : pix_addr;
    assign upd_we   = i_cmd.depth_upd && (r_quo < r_rdata);

    // Status back to the controller.
    assign o_status.degenerate = (area == '0) || (area_mag < EDGE_W'(r_limit));
    assign o_status.box_empty  = r_box_empty;
    assign o_status.covered    = !r_edge[1][EDGE_W-1] && !r_edge[2][EDGE_W-1]
                                 && !r_edge[3][EDGE_W-1];
    assign o_status.pix_last   = (r_px == r_maxx) && (r_py == r_maxy);
    assign o_status.sweep_last = &r_sweep;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_W'(1);
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // Item capture and vertex swap for clockwise triangles.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_x[0] <= i_v0x; r_y[0] <= i_v0y; r_d[0] <= i_v0d;
            r_x[1] <= i_v1x; r_y[1] <= i_v1y; r_d[1] <= i_v1d;
            r_x[2] <= i_v2x; r_y[2] <= i_v2y; r_d[2] <= i_v2d;
            r_col  <= i_col;
            r_row  <= i_row;
            r_oob  <= (EXT_W'(i_col) >= SIDE_EXT) || (EXT_W'(i_row) >= SIDE_EXT);
        end else if (i_cmd.setup && area[EDGE_W-1]) begin
            r_x[1] <= r_x[2]; r_y[1] <= r_y[2]; r_d[1] <= r_d[2];
            r_x[2] <= r_x[1]; r_y[2] <= r_y[1]; r_d[2] <= r_d[1];
        end
    end

    // Multiplier, accumulator and edge registers.
    always_ff @(posedge i_clk) begin
        r_prod <= prod_c;
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= r_prod;
            ACC_ADD:  r_acc <= r_acc + r_prod;
            default:  r_acc <= r_acc;
        endcase
        if (i_cmd.edge_wr) begin
            r_edge[i_cmd.edge_sel] <= EDGE_W'(r_acc - r_prod);
        end else if (i_cmd.setup && area[EDGE_W-1]) begin
            r_edge[0] <= -area;
        end
    end

    // Bounding box and pixel walk.
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_minx      <= lox[AW-1:0];
            r_maxx      <= hix[AW-1:0];
            r_miny      <= loy[AW-1:0];
            r_maxy      <= hiy[AW-1:0];
            r_box_empty <= (hix < lox) || (hiy < loy);
        end
        if (i_cmd.pix_init) begin
            r_px <= r_minx;
            r_py <= r_miny;
        end else if (i_cmd.pix_next) begin
            if (r_px == r_maxx) begin
                r_px <= r_minx;
                r_py <= r_py + 1'b1;
            end else begin
                r_px <= r_px + 1'b1;
            end
        end
    end

    // Restoring divider, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= EDGE_W'(unsigned'(r_acc[PROD_W-1:DEPTH_W]));
            r_nlo <= r_acc[DEPTH_W-1:0];
        end else if (i_cmd.div_step) begin
            if (div_t >= div_a) begin
                r_rem <= EDGE_W'(div_t - div_a);
                r_quo <= {r_quo[DEPTH_W-2:0], 1'b1};
            end else begin
                r_rem <= EDGE_W'(div_t);
                r_quo <= {r_quo[DEPTH_W-2:0], 1'b0};
            end
            r_nlo <= {r_nlo[DEPTH_W-2:0], 1'b0};
        end
    end

    // Updated pixel count, saturating.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_count <= '0;
        end else if (upd_we && (r_count != COUNT_MAX)) begin
            r_count <= r_count + 1'b1;
        end
    end

    // Clearing sweep address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep_init) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep_wr) begin
            r_sweep <= r_sweep + 1'b1;
        end
    end

    // Depth store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_wr) begin
            r_mem[r_sweep] <= DEPTH_MAX;
        end else if (upd_we) begin
            r_mem[pix_addr] <= r_quo;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_depth <= '0;
            r_res_count <= '0;
            r_res_skip  <= 1'b0;
            case (i_cmd.res_kind)
                RES_READ: r_res_depth <= r_oob ? '0 : r_rdata;
                RES_DRAW: r_res_count <= r_count;
                RES_SKIP: r_res_skip  <= 1'b1;
                default: begin
                end
            endcase
        end
    end

    assign o_read_depth = r_res_depth;
    assign o_pixels     = r_res_count;
    assign o_skipped    = r_res_skip;

endmodule

FILE: rtl/tdr_ctrl.sv
// Controller: sequences area, box walk, edge tests, depth division and store access.
module tdr_ctrl
    import tdr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [OP_W-1:0]  i_op,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_dp_cmd          o_cmd,
    input  t_dp_status       i_status
);

    typedef enum logic [11:0] {
        S_SWEEP = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_AREA  = 12'b0000_0000_0100,
        S_SETUP = 12'b0000_0000_1000,
        S_BOX   = 12'b0000_0001_0000,
        S_EDGE  = 12'b0000_0010_0000,
        S_TEST  = 12'b0000_0100_0000,
        S_DMUL  = 12'b0000_1000_0000,
        S_DIV   = 12'b0001_0000_0000,
        S_UPD   = 12'b0010_0000_0000,
        S_READ  = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [1:0]        r_phase, n_phase;
    logic [1:0]        r_esel, n_esel;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_sweep_resp, n_sweep_resp;
    t_res_kind         r_res, n_res;
    logic              r_out_valid, n_out_valid;
    logic              accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // Next-state and command logic.
    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_esel       = r_esel;
        n_step       = r_step;
        n_sweep_resp = r_sweep_resp;
        n_res        = r_res;
        n_out_valid  = r_out_valid;
        o_cmd        = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_SWEEP: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_status.sweep_last) begin
                    n_sweep_resp = 1'b0;
                    n_res        = RES_ZERO;
                    n_state      = r_sweep_resp ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_item = 1'b1;
                    n_phase         = 2'd0;
                    case (t_op'(i_op))
                        OP_DRAW: n_state = S_AREA;
                        OP_CLEAR: begin
                            o_cmd.sweep_init = 1'b1;
                            n_sweep_resp     = 1'b1;
                            n_state          = S_SWEEP;
                        end
                        OP_READ: n_state = S_READ;
                        default: begin
                            n_res   = RES_ZERO;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            // Doubled area: two products, then their difference.
            S_AREA: begin
                o_cmd.edge_sel = 2'd0;
                case (r_phase)
                    2'd0: begin
                        o_cmd.mul_sel = MUL_T1;
                        n_phase       = 2'd1;
                    end
                    2'd1: begin
                        o_cmd.mul_sel = MUL_T2;
                        o_cmd.acc_op  = ACC_LOAD;
                        n_phase       = 2'd2;
                    end
                    default: begin
                        o_cmd.edge_wr = 1'b1;
                        n_phase       = 2'd0;
                        n_state       = S_SETUP;
                    end
                endcase
            end
            S_SETUP: begin
                if (i_status.degenerate) begin
                    n_res   = RES_SKIP;
                    n_state = S_DONE;
                end else begin
                    o_cmd.setup = 1'b1;
                    n_state     = S_BOX;
                end
            end
            S_BOX: begin
                if (i_status.box_empty) begin
                    n_res   = RES_DRAW;
                    n_state = S_DONE;
                end else begin
                    o_cmd.pix_init = 1'b1;
                    n_esel         = 2'd1;
                    n_phase        = 2'd0;
                    n_state        = S_EDGE;
                end
            end
            // Edge functions of all edges at the pixel center.
            S_EDGE: begin
                o_cmd.edge_sel = r_esel;
                case (r_phase)
                    2'd0: begin
                        o_cmd.mul_sel = MUL_T1;
                        n_phase       = 2'd1;
                    end
                    2'd1: begin
                        o_cmd.mul_sel = MUL_T2;
                        o_cmd.acc_op  = ACC_LOAD;
                        n_phase       = 2'd2;
                    end
                    default: begin
                        o_cmd.edge_wr = 1'b1;
                        n_phase       = 2'd0;
                        if (r_esel == 2'd3) begin
                            n_state = S_TEST;
                        end else begin
                            n_esel = r_esel + 1'b1;
                        end
                    end
                endcase
            end
            S_TEST: begin
                if (i_status.covered) begin
                    n_phase = 2'd0;
                    n_state = S_DMUL;
                end else if (i_status.pix_last) begin
                    n_res   = RES_DRAW;
                    n_state = S_DONE;
                end else begin
                    o_cmd.pix_next = 1'b1;
                    n_esel         = 2'd1;
                    n_state        = S_EDGE;
                end
            end
            // Weighted depth sum of the three vertices.
            S_DMUL: begin
                o_cmd.mul_sel   = MUL_DEPTH;
                o_cmd.depth_sel = r_phase;
                case (r_phase)
                    2'd0: n_phase = 2'd1;
                    2'd1: begin
                        o_cmd.acc_op = ACC_LOAD;
                        n_phase      = 2'd2;
                    end
                    2'd2: begin
                        o_cmd.acc_op = ACC_ADD;
                        n_phase      = 2'd3;
                    end
                    default: begin
                        o_cmd.acc_op = ACC_ADD;
                        n_phase      = 2'd0;
                        n_step       = '0;
                        n_state      = S_DIV;
                    end
                endcase
            end
            S_DIV: begin
                if (r_step == '0) begin
                    o_cmd.div_init = 1'b1;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
                if (r_step == STEP_W'(DIV_STEPS)) begin
                    n_state = S_UPD;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_UPD: begin
                o_cmd.depth_upd = 1'b1;
                if (i_status.pix_last) begin
                    n_res   = RES_DRAW;
                    n_state = S_DONE;
                end else begin
                    o_cmd.pix_next = 1'b1;
                    n_esel         = 2'd1;
                    n_state        = S_EDGE;
                end
            end
            S_READ: begin
                o_cmd.addr_read = 1'b1;
                n_res           = RES_READ;
                n_state         = S_DONE;
            end
            S_DONE: begin
                o_cmd.addr_read = (r_res == RES_READ);
                o_cmd.res_kind  = r_res;
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Controller registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_phase      <= '0;
            r_esel       <= '0;
            r_step       <= '0;
            r_sweep_resp <= 1'b0;
            r_res        <= RES_ZERO;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_esel       <= n_esel;
            r_step       <= n_step;
            r_sweep_resp <= n_sweep_resp;
            r_res        <= n_res;
            r_out_valid  <= n_out_valid;
        end
    end

endmodule

FILE: rtl/triangle_depth_rasterizer.sv
// Top level: stream ports, configuration port, controller and datapath.
//
// Usage: each input transaction carries one operation in s_axis_tuser (draw, clear,
// read) and vertex and read fields in s_axis_tdata. Every operation produces one
// output transaction on the m_axis group. The area limit register is written through
// the cfg channel, which is always ready.
// Items are processed one at a time. A draw computes the area and bounding box,
// then for every pixel of the clamped box evaluates the edge functions on the
// shared multiplier, and for each covered pixel divides the weighted depth sum on
// the one-bit-per-cycle divider before the store update. A clear rewrites all
// 2^(2*ceil(log2 MAP_SIDE)) entries of the depth store (65536 at the default size),
// one entry per cycle.
// After reset the same clearing pass runs and s_axis_tready stays low until it ends.
// The result sits in an output register; a stalled receiver holds it while the next
// item is accepted and worked on, and that item waits for the register to free up.
module triangle_depth_rasterizer
    import tdr_pkg::*;
#(
    parameter int MAP_SIDE = MAP_SIDE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // vertex0_x, vertex0_y, vertex0_depth, vertex1_x, vertex1_y, vertex1_depth,
    // vertex2_x, vertex2_y, vertex2_depth, read_column, read_row
    input  logic [183:0]        s_axis_tdata,
    // operation
    input  logic [OP_W-1:0]     s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // read_depth, pixels_written, zero padding
    output logic [47:0]         m_axis_tdata,
    // status
    output logic                m_axis_tuser,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [LIMIT_W-1:0]  i_cfg_data
);

    t_dp_cmd            cmd;
    t_dp_status         status;
    logic [DEPTH_W-1:0] read_depth;
    logic [COUNT_W-1:0] pixels;

    assign o_cfg_ready = 1'b1;

    tdr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    tdr_datapath #(
        .MAP_SIDE (MAP_SIDE)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_v0x        (s_axis_tdata[15:0]),
        .i_v0y        (s_axis_tdata[31:16]),
        .i_v0d        (s_axis_tdata[55:32]),
        .i_v1x        (s_axis_tdata[71:56]),
        .i_v1y        (s_axis_tdata[87:72]),
        .i_v1d        (s_axis_tdata[111:88]),
        .i_v2x        (s_axis_tdata[127:112]),
        .i_v2y        (s_axis_tdata[143:128]),
        .i_v2d        (s_axis_tdata[167:144]),
        .i_col        (s_axis_tdata[175:168]),
        .i_row        (s_axis_tdata[183:176]),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_read_depth (read_depth),
        .o_pixels     (pixels),
        .o_skipped    (m_axis_tuser)
    );

    // Output payload packing.
    assign m_axis_tdata = {7'd0, pixels, read_depth};

endmodule
